/* sv/normalized_difference_vector_defines.svh */
// Assertion macros for the normalized difference vector block.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef NORMALIZED_DIFFERENCE_VECTOR_DEFINES_SVH
`define NORMALIZED_DIFFERENCE_VECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define NDV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define NDV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NDV_ASSERT_NOW(label, ante, cons)
`define NDV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/ndv_pkg.sv */
// Widths, step counts and stage payload types for the normalized difference vector.
// No dependencies.
package ndv_pkg;
	localparam int CoordW   = 32;
	localparam int DiffW    = CoordW + 1;
	localparam int SqW      = 2 * DiffW;
	localparam int RootW    = DiffW;
	localparam int RemW     = RootW + 2;
	localparam int QuotW    = 31;
	localparam int UnitW    = 32;
	localparam int Lanes    = 3;
	localparam int InDataW  = 2 * Lanes * CoordW;
	localparam int OutDataW = Lanes * UnitW;

	// One root bit per square-root stage, one quotient bit per divide stage
	localparam int SqrtSteps = RootW;
	localparam int DivSteps  = QuotW;

	typedef struct packed {
		logic [SqW-1:0]               rad;
		logic [RemW-1:0]              rem;
		logic [RootW-1:0]             root;
		logic [Lanes-1:0][DiffW-1:0]  mag;
		logic [Lanes-1:0]             sgn;
		logic                         zero;
	} sqrt_stage_t;

	typedef struct packed {
		logic [RootW-1:0]             len;
		logic [Lanes-1:0][DiffW-1:0]  mag;
		logic [Lanes-1:0][DiffW-1:0]  rem;
		logic [Lanes-1:0][QuotW-1:0]  quo;
		logic [Lanes-1:0]             sgn;
		logic                         zero;
	} div_stage_t;
endpackage

/* sv/normalized_difference_vector.sv */
// Unit direction from point B to point A: fully pipelined top level.
// Depends on ndv_pkg and normalized_difference_vector_defines.svh.
//
// Usage:
//   Slave channel s_axis_* carries one word per pair of points, six signed
//   Q16.16 coordinates. Master channel m_axis_* returns the unit vector as
//   three signed Q2.30 components, truncated toward zero, with tuser set
//   when the points coincide (components are then zero).
//   The result word reaches m_axis from the accepting edge
//   through 68 register stages: subtract, square, sum, 33 square-root
//   stages (one root bit each), 31 divide stages (one quotient bit per lane
//   each) and an output stage.
//   Throughput is one word per cycle while the receiver does not stall; the depth is set by the bit-serial
//   square root and the restoring divide, each cut one bit to a stage.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops in the same cycle; nothing is lost or repeated.
//   Reset clears every valid bit; payload registers are not reset.
`include "normalized_difference_vector_defines.svh"
module normalized_difference_vector (
	input  logic                          clk,
	input  logic                          arst_n,
	// point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z
	input  logic [ndv_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// unit_x, unit_y, unit_z
	output logic [ndv_pkg::OutDataW-1:0]  m_axis_tdata,
	// zero_length
	output logic                          m_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready
);
	import ndv_pkg::*;

	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic [SqrtSteps-1:0] sq_vld;
	logic [DivSteps-1:0]  dv_vld;
	logic out_vld_q;

	logic [Lanes-1:0][DiffW-1:0] mag_s1, mag_s2, mag_s3;
	logic [Lanes-1:0]            sgn_s1, sgn_s2, sgn_s3;
	logic [Lanes-1:0][SqW-1:0]   sq_s2;
	logic [SqW-1:0]              sum_s3;
	logic                        zero_s3;

	sqrt_stage_t sq_st [SqrtSteps];
	div_stage_t  dv_st [DivSteps];

	logic [Lanes-1:0][UnitW-1:0] unit_q;
	logic                        zero_q;

	// Advance every stage together whenever the output word can move
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			sq_vld    <= '0;
			dv_vld    <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			sq_vld    <= {sq_vld[SqrtSteps-2:0], vld_s3};
			dv_vld    <= {dv_vld[DivSteps-2:0], sq_vld[SqrtSteps-1]};
			out_vld_q <= dv_vld[DivSteps-1];
		end
	end

	// Stage 1: exact 33-bit difference, split into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Lanes; i++) begin
				logic signed [DiffW-1:0] a, b, d;
				a = DiffW'($signed(s_axis_tdata[i*CoordW +: CoordW]));
				b = DiffW'($signed(s_axis_tdata[(i+Lanes)*CoordW +: CoordW]));
				d = a - b;
				sgn_s1[i] <= d[DiffW-1];
				mag_s1[i] <= d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
			end
		end
	end

	// Stage 2: square each magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Lanes; i++)
				sq_s2[i] <= SqW'(mag_s1[i]) * SqW'(mag_s1[i]);
			mag_s2 <= mag_s1;
			sgn_s2 <= sgn_s1;
		end
	end

	// Stage 3: sum of squares, flag a zero length
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			zero_s3 <= (sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0;
			mag_s3  <= mag_s2;
			sgn_s3  <= sgn_s2;
		end
	end

	// Square root: one restoring step per stage, two radicand bits each
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		sqrt_stage_t prev;
		logic [RemW-1:0] rem_sh, trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign prev.rad  = sum_s3;
			assign prev.rem  = '0;
			assign prev.root = '0;
			assign prev.mag  = mag_s3;
			assign prev.sgn  = sgn_s3;
			assign prev.zero = zero_s3;
		end else begin : g_next
			assign prev = sq_st[k-1];
		end

		assign rem_sh = {prev.rem[RemW-3:0], prev.rad[SqW-1 -: 2]};
		assign trial  = {prev.root, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_st[k].rad  <= {prev.rad[SqW-3:0], 2'b00};
				sq_st[k].rem  <= ge ? rem_sh - trial : rem_sh;
				sq_st[k].root <= {prev.root[RootW-2:0], ge};
				sq_st[k].mag  <= prev.mag;
				sq_st[k].sgn  <= prev.sgn;
				sq_st[k].zero <= prev.zero;
			end
		end
	end

	// Divide: one quotient bit per lane per stage, magnitude times 2^30 over length
	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		div_stage_t prev;
		logic [Lanes-1:0] nb;

		if (j == 0) begin : g_first
			always_comb begin
				prev.len  = sq_st[SqrtSteps-1].root;
				prev.mag  = sq_st[SqrtSteps-1].mag;
				prev.sgn  = sq_st[SqrtSteps-1].sgn;
				prev.zero = sq_st[SqrtSteps-1].zero;
				prev.quo  = '0;
				for (int i = 0; i < Lanes; i++) begin
					prev.rem[i] = {1'b0, sq_st[SqrtSteps-1].mag[i][DiffW-1:1]};
					nb[i]       = sq_st[SqrtSteps-1].mag[i][0];
				end
			end
		end else begin : g_next
			assign prev = dv_st[j-1];
			assign nb   = '0;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < Lanes; i++) begin
					logic [DiffW:0] rs;
					logic           ge;
					rs = {prev.rem[i], nb[i]};
					ge = rs >= {1'b0, prev.len};
					dv_st[j].rem[i] <= ge ? DiffW'(rs - {1'b0, prev.len}) : DiffW'(rs);
					dv_st[j].quo[i] <= {prev.quo[i][QuotW-2:0], ge};
				end
				dv_st[j].len  <= prev.len;
				dv_st[j].mag  <= prev.mag;
				dv_st[j].sgn  <= prev.sgn;
				dv_st[j].zero <= prev.zero;
			end
		end
	end

	// Output stage: apply sign, force zeros for coinciding points
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Lanes; i++) begin
				logic [UnitW-1:0] q;
				q = {1'b0, dv_st[DivSteps-1].quo[i]};
				if (dv_st[DivSteps-1].zero)
					unit_q[i] <= '0;
				else
					unit_q[i] <= dv_st[DivSteps-1].sgn[i] ? -q : q;
			end
			zero_q <= dv_st[DivSteps-1].zero;
		end
	end

	assign m_axis_tdata  = unit_q;
	assign m_axis_tuser  = zero_q;
	assign m_axis_tvalid = out_vld_q;

	`NDV_ASSERT_NOW(a_zero_gives_zeros, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
	`NDV_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`NDV_ASSERT_NOW(a_unit_x_range, m_axis_tvalid,
		$signed(unit_q[0]) <= 32'sd1073741824 && $signed(unit_q[0]) >= -32'sd1073741824)
	`NDV_ASSERT_NOW(a_ready_follows_out, !m_axis_tvalid, s_axis_tready)
endmodule

/* sim/normalized_difference_vector_tb.sv */
// Self-checking bench for normalized_difference_vector: random and directed point pairs.
// Depends on ndv_pkg and the block itself; computes each unit vector independently.
module normalized_difference_vector_tb;
	import ndv_pkg::*;

	localparam int Latency   = 67;
	localparam int CycleCap  = 400000;
	localparam int RandItems = 600;

	typedef struct {
		logic [UnitW-1:0] ux;
		logic [UnitW-1:0] uy;
		logic [UnitW-1:0] uz;
		logic             coincide;
	} unit_vec_t;

	// Pending unit vectors and the mismatch count
	class unit_vec_board;
		unit_vec_t pending[$];
		int        errors;

		function automatic logic [DiffW-1:0] root_floor(logic [SqW-1:0] s);
			logic [DiffW-1:0] r;
			logic [DiffW-1:0] c;
			r = '0;
			for (int b = DiffW - 1; b >= 0; b--) begin
				c = r | (33'd1 << b);
				if (SqW'(c) * SqW'(c) <= s)
					r = c;
			end
			return r;
		endfunction

		function automatic logic [UnitW-1:0] scale(logic signed [DiffW-1:0] d,
				logic [DiffW-1:0] len);
			logic [DiffW-1:0] m;
			logic [63:0]      q;
			m = d[DiffW-1] ? -d : d;
			q = ({31'd0, m} << 30) / {31'd0, len};
			if (d[DiffW-1])
				q = -q;
			return q[UnitW-1:0];
		endfunction

		// Work out the unit vector for one accepted pair of points
		function void note_points(logic [InDataW-1:0] w);
			logic signed [DiffW-1:0] d[Lanes];
			logic [SqW-1:0]          s;
			logic [DiffW-1:0]        len;
			unit_vec_t               e;
			s = '0;
			for (int i = 0; i < Lanes; i++) begin
				d[i] = DiffW'($signed(w[i*CoordW +: CoordW]))
					- DiffW'($signed(w[(i+3)*CoordW +: CoordW]));
				s += SqW'(d[i][DiffW-1] ? -d[i] : d[i]) ** 2;
			end
			if (s == 0) begin
				e = '{0, 0, 0, 1'b1};
			end else begin
				len = root_floor(s);
				e = '{scale(d[0], len), scale(d[1], len), scale(d[2], len), 1'b0};
			end
			pending.push_back(e);
		endfunction

		// Compare a result word with the oldest pending unit vector
		function void check_word(logic [OutDataW-1:0] data, logic user);
			unit_vec_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h user %b", $time, data, user);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.ux) begin
				$display("%0t: unit_x expected %h actual %h", $time, e.ux, data[31:0]);
				errors++;
			end
			if (data[63:32] !== e.uy) begin
				$display("%0t: unit_y expected %h actual %h", $time, e.uy, data[63:32]);
				errors++;
			end
			if (data[95:64] !== e.uz) begin
				$display("%0t: unit_z expected %h actual %h", $time, e.uz, data[95:64]);
				errors++;
			end
			if (user !== e.coincide) begin
				$display("%0t: zero_length expected %b actual %b", $time, e.coincide, user);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;

	unit_vec_board board = new();
	int  cycles;
	bit  long_hold;
	bit  sink_free;

	normalized_difference_vector dut (
		.clk, .arst_n, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
		.m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready
	);

	always #1 clk = ~clk;

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_points(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata, m_axis_tuser);
		if (cycles > CycleCap) begin
			$display("normalized_difference_vector verification failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, one long hold while the pipe fills
	initial begin
		int g;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !held) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				held = 1'b1;
			end
			if (sink_free) begin
				m_axis_tready <= 1'b1;
			end else begin
				g = gap_len();
				m_axis_tready <= (g == 0);
				if (g > 0)
					repeat (g - 1) @(negedge clk);
			end
		end
	end

	// Offer one word and hold it until taken
	task automatic send_points(logic [InDataW-1:0] w, bit allow_gap);
		int g;
		g = allow_gap ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tdata  <= w;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [CoordW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 7) - 4;
			3: return {{16{$urandom_range(0,1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [InDataW-1:0] rand_pair();
		logic [InDataW-1:0] w;
		for (int i = 0; i < 2 * Lanes; i++)
			w[i*CoordW +: CoordW] = rand_coord();
		// Sometimes make the points coincide or differ only slightly
		if ($urandom_range(0, 9) == 0)
			w[191:96] = w[95:0];
		else if ($urandom_range(0, 9) == 0)
			w[191:96] = w[95:0] ^ 96'($urandom_range(1, 7));
		return w;
	endfunction

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [CoordW-1:0] mn, mx;
		mn = 32'h8000_0000;
		mx = 32'h7fff_ffff;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: coinciding points, extremes, unit axes, tiny differences
		send_points('0, 0);
		send_points({3{mn, mn}}, 0);
		send_points({mx, mx, mx, mn, mn, mn}, 0);
		send_points({mn, mn, mn, mx, mx, mx}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hffff_ffff}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1}, 0);
		send_points({32'd0, 32'd0, 32'd0, 32'hffff_ffff, 32'd1, 32'd1}, 0);
		send_points({32'd0, 32'd0, 32'd0, mx, 32'd0, mn}, 0);
		send_points({mx, 32'd0, 32'd0, mn, 32'd0, 32'd0}, 0);
		send_points({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 96'd0}, 0);
		send_points({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000}, 0);
		send_points({96'h5555_5555_aaaa_aaaa_1234_5678, 96'h5555_5555_aaaa_aaaa_1234_5678}, 0);

		// Sender pauses until the pipeline is empty
		drain();

		// Back-to-back burst against a long receiver hold
		long_hold = 1'b1;
		for (int i = 0; i < 150; i++)
			send_points(rand_pair(), 0);

		for (int i = 0; i < RandItems - 150; i++)
			send_points(rand_pair(), i % 97 > 60);

		s_axis_tvalid <= 1'b0;
		sink_free = 1'b1;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		if (board.errors == 0)
			$display("normalized_difference_vector verification clean");
		else
			$display("normalized_difference_vector verification failed");
		$finish;
	end
endmodule
